// ===== hdl/pap_pkg.sv =====
package pap_pkg;

    localparam int POS_WIDTH = 16;
    localparam int CFG_W     = 16;
    localparam int SPEED_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 8;

    localparam int COORD_W = (POS_WIDTH > CFG_W) ? POS_WIDTH : CFG_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int AW      = COORD_W;
    localparam int SQ_W    = 2 * AW;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RAD_W   = SUM_W + (SUM_W % 2);
    localparam int DIST_W  = RAD_W / 2;

    localparam int MUL_MAX = (AW > DIST_W) ? ((AW > CFG_W) ? AW : CFG_W)
                                           : ((DIST_W > CFG_W) ? DIST_W : CFG_W);
    localparam int MUL_A   = MUL_MAX + 1;
    localparam int PROD_W  = 2 * MUL_A;

    localparam int NUM_W   = DIST_W + CFG_W + 1;
    localparam int OFF_W   = NUM_W + 1;
    localparam int QUO_W   = DIST_W + CFG_W - 1;
    localparam int DEN_W   = CFG_W + 2;
    localparam int DVS_W   = CFG_W + 1;
    localparam int S_W     = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 1;

    localparam int STEPS   = (DIST_W > QUO_W) ? DIST_W : QUO_W;
    localparam int CNT_W   = $clog2(STEPS);

    localparam logic signed [CFG_W-1:0] TARGET_X_RST   = '0;
    localparam logic signed [CFG_W-1:0] TARGET_Y_RST   = '0;
    localparam logic [CFG_W-1:0]        DECEL_RST      = 16'd256;
    localparam logic signed [CFG_W-1:0] ACCEL_RST      = -16'sd128;
    localparam logic [SPEED_W-1:0]      SPEED_MIN_RST  = 10'd50;
    localparam logic [SPEED_W-1:0]      SPEED_MAX_RST  = 10'd500;
    localparam logic [SPEED_W-1:0]      ARRIVE_EPS_RST = 10'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_X   = 3'd0,
        CFG_TARGET_Y   = 3'd1,
        CFG_DECEL      = 3'd2,
        CFG_ACCEL      = 3'd3,
        CFG_SPEED_MIN  = 3'd4,
        CFG_SPEED_MAX  = 3'd5,
        CFG_ARRIVE_EPS = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_SQ_X   = 2'd0,
        MUL_SQ_Y   = 2'd1,
        MUL_ACC_D  = 2'd2,
        MUL_LINE_D = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
    } req_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               arrived;
    } rsp_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_first;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     mark_arrived;
        logic     latch;
        logic     div_step;
        logic     div_done;
        logic     result_write;
    } pap_cmd_t;

    typedef struct packed {
        logic arrive_hit;
        logic need_latch;
    } pap_sts_t;

endpackage

// ===== hdl/pap_dp.sv =====
module pap_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pap_pkg::CFG_W-1:0]     cfg_data,
    input  pap_pkg::req_t                 req_data,
    input  pap_pkg::pap_cmd_t             cmd,
    output pap_pkg::pap_sts_t             sts,
    output pap_pkg::rsp_t                 rsp_data
);
    import pap_pkg::*;

    // configuration
    logic signed [CFG_W-1:0] target_x_reg;
    logic signed [CFG_W-1:0] target_y_reg;
    logic [CFG_W-1:0]        decel_reg;
    logic signed [CFG_W-1:0] accel_reg;
    logic [SPEED_W-1:0]      speed_min_reg;
    logic [SPEED_W-1:0]      speed_max_reg;
    logic [SPEED_W-1:0]      arrive_eps_reg;

    // approach state
    logic                    reached_reg;
    logic [DIST_W-1:0]       start_reg;
    logic signed [OFF_W-1:0] offset_reg;
    logic [QUO_W-1:0]        cross_reg;

    // working registers
    logic [AW-1:0]            ax_reg;
    logic [AW-1:0]            ay_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]          sum_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [DIST_W:0]          rem_reg;
    logic [DIST_W-1:0]        root_reg;
    logic [QUO_W-1:0]         dvd_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic [DVS_W-1:0]         drem_reg;
    logic                     zero_q_reg;
    rsp_t                     rsp_reg;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [AW-1:0]            ax_c;
    logic [AW-1:0]            ay_c;
    logic signed [MUL_A-1:0]  mul_a;
    logic signed [MUL_A-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     line_dec;
    logic [DIST_W+2:0]        rem_sh;
    logic [DIST_W+2:0]        trial;
    logic                     sq_ge;
    logic [DVS_W:0]           dr_sh;
    logic                     dv_ge;
    logic signed [NUM_W-1:0]  num_c;
    logic signed [DEN_W-1:0]  den_c;
    logic signed [OFF_W-1:0]  offset_c;
    logic [SPEED_W+FRAC_W-1:0] min_q;
    logic signed [S_W-1:0]    addend;
    logic signed [S_W-1:0]    s_sum;
    logic [S_W-FRAC_W-1:0]    s_int;
    logic [SPEED_W-1:0]       speed_c;

    assign dx   = DIFF_W'(target_x_reg) - DIFF_W'(req_data.pos_x);
    assign dy   = DIFF_W'(target_y_reg) - DIFF_W'(req_data.pos_y);
    assign ax_c = dx[DIFF_W-1] ? AW'(-dx) : AW'(dx);
    assign ay_c = dy[DIFF_W-1] ? AW'(-dy) : AW'(dy);

    assign line_dec = QUO_W'(root_reg) < cross_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQ_X:
            begin
                mul_a = MUL_A'(ax_reg);
                mul_b = MUL_A'(ax_reg);
            end
            MUL_SQ_Y:
            begin
                mul_a = MUL_A'(ay_reg);
                mul_b = MUL_A'(ay_reg);
            end
            MUL_ACC_D:
            begin
                mul_a = MUL_A'(accel_reg);
                mul_b = MUL_A'(root_reg);
            end
            MUL_LINE_D:
            begin
                mul_a = line_dec ? MUL_A'(decel_reg) : MUL_A'(accel_reg);
                mul_b = MUL_A'(root_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // square root, one result bit per step
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = (DIST_W+3)'({root_reg, 2'b01});
    assign sq_ge  = rem_sh >= trial;

    // restoring divide, one quotient bit per step
    assign dr_sh = {drem_reg, dvd_reg[QUO_W-1]};
    assign dv_ge = dr_sh >= (DVS_W+1)'(dvs_reg);

    // crossing setup, prod_reg holds accel * d
    assign num_c    = NUM_W'(-prod_reg);
    assign den_c    = DEN_W'(decel_reg) - DEN_W'(accel_reg);
    assign min_q    = {speed_min_reg, {FRAC_W{1'b0}}};
    assign offset_c = OFF_W'(min_q) + OFF_W'(num_c);

    // speed from the chosen line
    assign addend  = line_dec ? S_W'(min_q) : S_W'(offset_reg);
    assign s_sum   = S_W'(prod_reg) + addend;
    assign s_int   = s_sum[S_W-1:FRAC_W];
    always_comb
    begin
        if (s_sum[S_W-1])
            speed_c = '0;
        else if (s_int > (S_W-FRAC_W)'(speed_max_reg))
            speed_c = speed_max_reg;
        else
            speed_c = s_int[SPEED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg   <= TARGET_X_RST;
            target_y_reg   <= TARGET_Y_RST;
            decel_reg      <= DECEL_RST;
            accel_reg      <= ACCEL_RST;
            speed_min_reg  <= SPEED_MIN_RST;
            speed_max_reg  <= SPEED_MAX_RST;
            arrive_eps_reg <= ARRIVE_EPS_RST;
            reached_reg    <= 1'b0;
            start_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_X:   target_x_reg   <= cfg_data;
                    CFG_TARGET_Y:   target_y_reg   <= cfg_data;
                    CFG_DECEL:      decel_reg      <= cfg_data;
                    CFG_ACCEL:      accel_reg      <= cfg_data;
                    CFG_SPEED_MIN:  speed_min_reg  <= cfg_data[SPEED_W-1:0];
                    CFG_SPEED_MAX:  speed_max_reg  <= cfg_data[SPEED_W-1:0];
                    CFG_ARRIVE_EPS: arrive_eps_reg <= cfg_data[SPEED_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.mark_arrived)
                reached_reg <= 1'b1;
            if (cmd.latch)
                start_reg <= root_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= ax_c;
            ay_reg <= ay_c;
        end
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.sum_first)
            sum_reg <= prod_reg[SQ_W-1:0];
        if (cmd.sqrt_init)
        begin
            rad_reg  <= RAD_W'(sum_reg) + RAD_W'(prod_reg[SQ_W-1:0]);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (sq_ge)
            begin
                rem_reg  <= (DIST_W+1)'(rem_sh - trial);
                root_reg <= {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[DIST_W:0];
                root_reg <= {root_reg[DIST_W-2:0], 1'b0};
            end
        end
        if (cmd.latch)
        begin
            offset_reg <= offset_c;
            dvd_reg    <= num_c[NUM_W-1] ? QUO_W'(-num_c) : QUO_W'(num_c);
            dvs_reg    <= den_c[DEN_W-1] ? DVS_W'(-den_c) : DVS_W'(den_c);
            drem_reg   <= '0;
            zero_q_reg <= (den_c == '0) || (num_c[NUM_W-1] != den_c[DEN_W-1]);
        end
        else if (cmd.div_step)
        begin
            if (dv_ge)
            begin
                drem_reg <= DVS_W'(dr_sh - (DVS_W+1)'(dvs_reg));
                dvd_reg  <= {dvd_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dr_sh[DVS_W-1:0];
                dvd_reg  <= {dvd_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.div_done)
            cross_reg <= zero_q_reg ? '0 : dvd_reg;
        if (cmd.result_write)
        begin
            rsp_reg.speed   <= reached_reg ? '0 : speed_c;
            rsp_reg.arrived <= reached_reg;
        end
    end

    assign sts.arrive_hit = reached_reg || (root_reg < DIST_W'(arrive_eps_reg));
    assign sts.need_latch = (start_reg == '0);
    assign rsp_data       = rsp_reg;

endmodule

// ===== hdl/pap_ctrl.sv =====
module pap_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  pap_pkg::pap_sts_t     sts,
    output pap_pkg::pap_cmd_t     cmd
);
    import pap_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MUL_X = 12'b0000_0000_0010,
        S_MUL_Y = 12'b0000_0000_0100,
        S_ADD   = 12'b0000_0000_1000,
        S_SQRT  = 12'b0000_0001_0000,
        S_CHECK = 12'b0000_0010_0000,
        S_MUL_A = 12'b0000_0100_0000,
        S_LATCH = 12'b0000_1000_0000,
        S_DIV   = 12'b0001_0000_0000,
        S_CROSS = 12'b0010_0000_0000,
        S_MUL_L = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             valid_reg;
    logic             valid_next;
    logic             slot_free;

    assign slot_free = !valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !rsp_ready;
        cmd        = '0;
        cmd.mul_sel = MUL_SQ_X;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ_X;
                state_next  = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_SQ_Y;
                cmd.sum_first = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = CNT_W'(DIST_W - 1);
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.arrive_hit)
                begin
                    cmd.mark_arrived = 1'b1;
                    state_next       = S_FIN;
                end
                else if (sts.need_latch)
                    state_next = S_MUL_A;
                else
                    state_next = S_MUL_L;
            end
            S_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ACC_D;
                state_next  = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.latch  = 1'b1;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = S_CROSS;
            end
            S_CROSS:
            begin
                cmd.div_done = 1'b1;
                state_next   = S_MUL_L;
            end
            S_MUL_L:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LINE_D;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.result_write = 1'b1;
                    valid_next       = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hdl/point_approach_speed_profile.sv =====
// Point approach speed profile. Each request carries the current position; the block
// returns one result with the commanded speed for both wheels and a sticky arrived
// flag. Distance to the configured target is the floor square root of the squared
// distance, worked out one result bit per cycle; on the first request of an approach
// (stored start distance zero) the block latches the distance, the acceleration line
// offset and the crossing distance, the latter from a restoring divider that yields
// one quotient bit per cycle. All products share one 18x18 multiplier. An accepted request
// squares the two offsets, takes the 17-step square root and checks for arrival; on the
// latching request it forms the line offset and runs the 32-step divide; it then forms the
// speed (arrival skips this) and loads the result register once the output slot is free.
// One request is in work at a time; a new one is accepted while the previous
// result still waits in the output register. Configuration writes are taken in any
// cycle and must be issued while the block is idle.
module point_approach_speed_profile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  pap_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output pap_pkg::rsp_t                 rsp_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pap_pkg::CFG_W-1:0]     cfg_data
);
    import pap_pkg::*;

    pap_cmd_t cmd;
    pap_sts_t sts;

    assign cfg_ready = 1'b1;

    pap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pap_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_data  (rsp_data)
    );

endmodule
